// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/ssad_pkg.sv
// ----------------------------------------------------------------------------
// ssad_pkg
// shared types and constants of the segment sort block
// ----------------------------------------------------------------------------
package ssad_pkg;

  localparam int unsigned VALUE_W    = 25;
  localparam int unsigned BOUND_W    = 7;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic {
    MODE_APPEND = 1'b0,
    MODE_SORT   = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_RUN,
    S_TAIL,
    S_LOAD,
    S_WAIT
  } state_e;

endpackage

// File: rtl/core/ssad_ram.sv
// ----------------------------------------------------------------------------
// ssad_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ssad_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/segment_sort_asc_desc_top.sv
// ----------------------------------------------------------------------------
// segment_sort_asc_desc_top
// element store with in-place segment sort and full-array readout
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                                | tuser  | tlast
//  s_axis   | in  | value[24:0] seg_start[31:25] seg_end[38:32] desc[39] | mode   | -
//  m_axis   | out | element[24:0] position[30:25] zero[31]            | status | last
//
//  append: no result; error results are registered in the output register
//  sort of n = seg_end - seg_start + 1 elements: bubble passes over the segment
//  through the ram's one write port and one read port, then the whole array is
//  emitted, each element read from the ram into the output register
//  a new transfer is taken only when idle and the output register is empty
//  rst_ni clears the element count and control; ram contents are not cleared
// ----------------------------------------------------------------------------
module segment_sort_asc_desc_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // value, seg_start, seg_end, descending
  input  logic [ssad_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // mode
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // element, position
  output logic [ssad_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [ssad_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ssad_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] end_q, end_d;
  logic [IW-1:0] j_q, j_d;
  logic          desc_q, desc_d;
  ssad_pkg::value_t carry_q, carry_d;

  logic                     out_valid_q, out_valid_d;
  ssad_pkg::value_t         out_elem_q, out_elem_d;
  logic [ssad_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic                     out_last_q, out_last_d;
  ssad_pkg::status_e        out_status_q, out_status_d;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  ssad_pkg::value_t         ram_wdata;
  logic [IW-1:0]            ram_raddr;
  logic [ssad_pkg::VALUE_W-1:0] ram_rdata;
  ssad_pkg::value_t         rdata_s;

  ssad_pkg::mode_e              in_mode;
  ssad_pkg::value_t             in_value;
  logic [ssad_pkg::BOUND_W-1:0] in_start;
  logic [ssad_pkg::BOUND_W-1:0] in_end;
  logic                         in_desc;
  logic                         in_fire;
  logic                         out_fire;
  logic                         bounds_ok;
  logic                         keep_carry;

  assign in_mode  = ssad_pkg::mode_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[24:0];
  assign in_start = s_axis_tdata[31:25];
  assign in_end   = s_axis_tdata[38:32];
  assign in_desc  = s_axis_tdata[39];

  assign s_axis_tready = (state_q == ssad_pkg::S_IDLE) && !out_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  assign bounds_ok = (in_start != '0) && (in_start < in_end) &&
                     (in_end <= ssad_pkg::BOUND_W'(count_q));

  assign rdata_s    = ram_rdata;
  assign keep_carry = desc_q ? (carry_q < rdata_s) : (carry_q > rdata_s);

  ssad_ram #(
    .WIDTH (ssad_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    end_d        = end_q;
    j_d          = j_q;
    desc_d       = desc_q;
    carry_d      = carry_q;
    out_valid_d  = out_valid_q;
    out_elem_d   = out_elem_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = j_q - IW'(1);
    ram_wdata    = carry_q;
    ram_raddr    = lo_q;

    unique case (state_q)
      ssad_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_mode == ssad_pkg::MODE_APPEND) begin
            if (count_q == CW'(DEPTH)) begin
              out_valid_d  = 1'b1;
              out_elem_d   = '0;
              out_pos_d    = '0;
              out_last_d   = 1'b1;
              out_status_d = ssad_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = IW'(count_q);
              ram_wdata = in_value;
              count_d   = count_q + CW'(1);
            end
          end else if (!bounds_ok) begin
            out_valid_d  = 1'b1;
            out_elem_d   = '0;
            out_pos_d    = '0;
            out_last_d   = 1'b1;
            out_status_d = ssad_pkg::ST_BOUNDS;
          end else begin
            lo_d      = IW'(in_start - ssad_pkg::BOUND_W'(1));
            end_d     = IW'(in_end - ssad_pkg::BOUND_W'(1));
            desc_d    = in_desc;
            ram_raddr = IW'(in_start - ssad_pkg::BOUND_W'(1));
            state_d   = ssad_pkg::S_FIRST;
          end
        end
      end

      ssad_pkg::S_FIRST: begin
        carry_d   = rdata_s;
        ram_raddr = lo_q + IW'(1);
        j_d       = lo_q + IW'(1);
        state_d   = ssad_pkg::S_RUN;
      end

      // carry holds the extreme of lo..j-1, ram data is element j
      ssad_pkg::S_RUN: begin
        ram_we    = 1'b1;
        ram_waddr = j_q - IW'(1);
        if (keep_carry) begin
          ram_wdata = rdata_s;
        end else begin
          ram_wdata = carry_q;
          carry_d   = rdata_s;
        end
        if (j_q == end_q) begin
          state_d = ssad_pkg::S_TAIL;
        end else begin
          ram_raddr = j_q + IW'(1);
          j_d       = j_q + IW'(1);
        end
      end

      ssad_pkg::S_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = end_q;
        ram_wdata = carry_q;
        if (end_q > lo_q + IW'(1)) begin
          end_d     = end_q - IW'(1);
          ram_raddr = lo_q;
          state_d   = ssad_pkg::S_FIRST;
        end else begin
          ram_raddr = '0;
          j_d       = '0;
          state_d   = ssad_pkg::S_LOAD;
        end
      end

      ssad_pkg::S_LOAD: begin
        out_valid_d  = 1'b1;
        out_elem_d   = rdata_s;
        out_pos_d    = ssad_pkg::POS_W'(j_q);
        out_last_d   = (CW'(j_q) + CW'(1)) == count_q;
        out_status_d = ssad_pkg::ST_OK;
        state_d      = ssad_pkg::S_WAIT;
      end

      ssad_pkg::S_WAIT: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ssad_pkg::S_IDLE;
          end else begin
            ram_raddr = j_q + IW'(1);
            j_d       = j_q + IW'(1);
            state_d   = ssad_pkg::S_LOAD;
          end
        end
      end

      default: begin
        state_d = ssad_pkg::S_IDLE;
      end
    endcase

    // error results leave from idle
    if (state_q == ssad_pkg::S_IDLE && out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssad_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    end_q        <= end_d;
    j_q          <= j_d;
    desc_q       <= desc_d;
    carry_q      <= carry_d;
    out_elem_q   <= out_elem_d;
    out_pos_q    <= out_pos_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pos_q, out_elem_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/ssad_chk.sv
// ----------------------------------------------------------------------------
// ssad_chk
// port-level checks of the segment sort block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssad_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tuser,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [ssad_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [ssad_pkg::STATUS_W-1:0]   m_axis_tuser,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);

  logic err_out;
  logic in_fire;

  assign err_out = m_axis_tvalid && (m_axis_tuser != ssad_pkg::ST_OK);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
               $stable(m_axis_tlast))

  // error results stand alone and carry zero payload
  `ASSERT_IMPL(a_err_alone, err_out, m_axis_tlast && (m_axis_tdata == '0))

  // no input is taken while a result is pending
  `ASSERT_IMPL(a_one_at_a_time, s_axis_tready, !m_axis_tvalid)

  // a sort transfer is never answered in the following cycle by another intake
  `ASSERT_NEXT(a_sort_busy, in_fire && s_axis_tuser, !s_axis_tready)

endmodule

bind segment_sort_asc_desc_top ssad_chk u_ssad_chk (.*);

// File: test/segment_sort_asc_desc_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_sort_asc_desc_top_tb
// self-checking bench for the element store with segment sort and readout
//
// commands go in over s_axis, the array readout and error beats come back on
// m_axis. a tracker class mirrors the store, sorts the segment on its own
// copy and queues the expected beats; every m_axis transfer is compared
// field by field. a short directed list covers empty and one-element stores,
// bad bounds, both orders and extreme values; random commands then grow
// the store to full and keep sorting, under several idle and stall mixes
// ----------------------------------------------------------------------------

typedef struct {
  ssad_pkg::mode_e  mode;
  ssad_pkg::value_t value;
  logic [6:0]       seg_lo;
  logic [6:0]       seg_hi;
  logic             descending;
} seg_cmd_t;

typedef struct {
  ssad_pkg::value_t  element;
  logic [5:0]        position;
  logic              last;
  ssad_pkg::status_e status;
} array_beat_t;

class array_tracker;
  int                depth;
  int                count;
  int                errors;
  ssad_pkg::value_t  store[];
  array_beat_t       pending_beats[$];

  function new(int depth_i);
    depth  = depth_i;
    count  = 0;
    errors = 0;
    store  = new[depth_i];
  endfunction

  function int pending();
    return pending_beats.size();
  endfunction

  function void push_error(ssad_pkg::status_e st);
    array_beat_t b;
    b.element  = '0;
    b.position = '0;
    b.last     = 1'b1;
    b.status   = st;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // mirror one accepted command and queue what it should emit
  function void apply_cmd(seg_cmd_t c);
    int lo;
    int hi;
    int j;
    ssad_pkg::value_t key;
    array_beat_t b;
    if (c.mode == ssad_pkg::MODE_APPEND) begin
      if (count >= depth) begin
        push_error(ssad_pkg::ST_FULL);
      end else begin
        store[count] = c.value;
        count++;
      end
      return;
    end
    if (c.seg_lo < 1 || c.seg_lo >= c.seg_hi || c.seg_hi > count) begin
      push_error(ssad_pkg::ST_BOUNDS);
      return;
    end
    lo = c.seg_lo - 1;
    hi = c.seg_hi - 1;
    for (int i = lo + 1; i <= hi; i++) begin
      key = store[i];
      j = i;
      while (j > lo && (c.descending ? (store[j-1] < key) : (store[j-1] > key))) begin
        store[j] = store[j-1];
        j--;
      end
      store[j] = key;
    end
    for (int i = 0; i < count; i++) begin
      b.element  = store[i];
      b.position = 6'(i);
      b.last     = (i == count - 1);
      b.status   = ssad_pkg::ST_OK;
      pending_beats.insert(pending_beats.size(), b);
    end
  endfunction

  function void check_beat(logic [31:0] data, logic [1:0] user, logic last);
    array_beat_t want;
    ssad_pkg::value_t got_elem;
    logic [5:0] got_pos;
    got_elem = data[24:0];
    got_pos  = data[30:25];
    if (pending_beats.size() == 0) begin
      errors++;
      $display("%0t: transfer with nothing expected: element %0d position %0d status %0d last %0b",
               $time, got_elem, got_pos, user, last);
      return;
    end
    want = pending_beats.pop_front();
    if (got_elem !== want.element) begin
      errors++;
      $display("%0t: element mismatch: expected %0d actual %0d", $time, want.element, got_elem);
    end
    if (got_pos !== want.position) begin
      errors++;
      $display("%0t: position mismatch: expected %0d actual %0d", $time, want.position, got_pos);
    end
    if (last !== want.last) begin
      errors++;
      $display("%0t: last mismatch: expected %0b actual %0b", $time, want.last, last);
    end
    if (user !== want.status) begin
      errors++;
      $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, user);
    end
  endfunction
endclass

module segment_sort_asc_desc_top_tb;

  localparam int DEPTH       = 32;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 58;
  localparam int CYCLE_LIMIT = 2000000;

  logic                            clk_i;
  logic                            rst_ni;
  logic [ssad_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [ssad_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [ssad_pkg::STATUS_W-1:0]   m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;

  array_tracker sb;
  int           src_idle_pct;
  int           sink_stall_pct;
  bit           hold_req;
  int           cycle_count = 0;
  int           idle_tab[4]  = '{0, 47, 0, 32};
  int           stall_tab[4] = '{0, 0, 47, 32};

  segment_sort_asc_desc_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic ssad_pkg::value_t random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return ssad_pkg::value_t'(int'($urandom_range(19999998)) - 9999999);
    if (pick < 80) return ssad_pkg::value_t'($urandom());
    return ssad_pkg::value_t'(int'($urandom_range(4)) - 2);
  endfunction

  function automatic seg_cmd_t append_cmd(ssad_pkg::value_t v);
    seg_cmd_t c;
    c.mode       = ssad_pkg::MODE_APPEND;
    c.value      = v;
    c.seg_lo     = 7'($urandom());
    c.seg_hi     = 7'($urandom());
    c.descending = 1'($urandom());
    return c;
  endfunction

  function automatic seg_cmd_t sort_cmd(int lo, int hi, bit desc);
    seg_cmd_t c;
    c.mode       = ssad_pkg::MODE_SORT;
    c.value      = ssad_pkg::value_t'($urandom());
    c.seg_lo     = 7'(lo);
    c.seg_hi     = 7'(hi);
    c.descending = desc;
    return c;
  endfunction

  // appends, well-formed segments (mostly short, some wide) and some bad bounds
  function automatic seg_cmd_t random_cmd();
    int cnt;
    int lo;
    int room;
    int span;
    cnt = sb.count;
    if ($urandom_range(99) < 30) return append_cmd(random_value());
    if (cnt >= 2 && $urandom_range(99) < 75) begin
      lo   = $urandom_range(cnt - 1, 1);
      room = cnt - lo;
      if ($urandom_range(99) < 70) span = $urandom_range((room < 5) ? room : 5, 1);
      else span = $urandom_range(room, 1);
      return sort_cmd(lo, lo + span, $urandom_range(1));
    end
    if ($urandom_range(1)) return sort_cmd($urandom_range(127), $urandom_range(127),
                                           $urandom_range(1));
    return sort_cmd($urandom_range(cnt + 1), $urandom_range(cnt + 1), $urandom_range(1));
  endfunction

  task automatic send_cmd(seg_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {c.descending, c.seg_hi, c.seg_lo, c.value};
    s_axis_tuser  <= c.mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_cmd(c);
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb = new(DEPTH);
    hold_req       = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    s_axis_tvalid  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty and one-element stores, bad bounds, extremes, both orders
    send_cmd(sort_cmd(1, 2, 1'b0));
    send_cmd(append_cmd(ssad_pkg::value_t'(9999999)));
    send_cmd(sort_cmd(1, 1, 1'b0));
    send_cmd(sort_cmd(1, 2, 1'b1));
    send_cmd(append_cmd(ssad_pkg::value_t'(-9999999)));
    send_cmd(append_cmd(25'h0FFFFFF));
    send_cmd(append_cmd(25'h1000000));
    send_cmd(append_cmd('0));
    send_cmd(append_cmd('0));
    send_cmd(sort_cmd(1, 6, 1'b0));
    send_cmd(sort_cmd(1, 6, 1'b1));
    send_cmd(sort_cmd(0, 3, 1'b0));
    send_cmd(sort_cmd(4, 3, 1'b0));
    send_cmd(sort_cmd(3, 3, 1'b1));
    send_cmd(sort_cmd(2, 7, 1'b0));
    send_cmd(sort_cmd(127, 127, 1'b1));
    send_cmd(sort_cmd(2, 4, 1'b0));
    send_cmd(sort_cmd(5, 6, 1'b1));
    send_cmd(append_cmd(25'h1555555));
    send_cmd(append_cmd(25'h0AAAAAA));
    send_cmd(sort_cmd(1, 8, 1'b1));
    send_cmd(sort_cmd(1, 2, 1'b0));
    pause_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_tab[ph];
      sink_stall_pct = stall_tab[ph];
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd());
      pause_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
